// File: rtl/core/sbt_pkg.sv
// Shared types, codes and constants of the sorted box table.
`default_nettype none
package sbt_pkg;

	// Default number of table entries and the cap on overlap hits per request.
	localparam int TABLE_DEPTH_DEF = 64;
	localparam int MAX_RESULTS = 64;
	localparam int HIT_W = $clog2(MAX_RESULTS + 1);
	localparam int ID_W = 16;
	localparam int NEXT_ID_W = 17;

	// Command codes.
	localparam logic [2:0] CMD_REGISTER = 3'd0;
	localparam logic [2:0] CMD_UNREGISTER = 3'd1;
	localparam logic [2:0] CMD_GET = 3'd2;
	localparam logic [2:0] CMD_SET = 3'd3;
	localparam logic [2:0] CMD_OVERLAP = 3'd4;

	// Status codes.
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [2:0] cmd;
		logic [ID_W-1:0] box_id;
		logic signed [31:0] min_x;
		logic signed [31:0] min_y;
		logic signed [31:0] max_x;
		logic signed [31:0] max_y;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [ID_W-1:0] result_id;
		logic hit;
		logic signed [31:0] out_min_x;
		logic signed [31:0] out_min_y;
		logic signed [31:0] out_max_x;
		logic signed [31:0] out_max_y;
		logic last;
	} rsp_t;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic signed [31:0] min_x;
		logic signed [31:0] min_y;
		logic signed [31:0] max_x;
		logic signed [31:0] max_y;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_SHIFT,
		S_SCAN,
		S_SCAN_END
	} state_t;

	typedef enum logic [2:0] {
		EMIT_NONE,
		EMIT_REG,
		EMIT_FULL,
		EMIT_NOT_FOUND,
		EMIT_OK,
		EMIT_GET,
		EMIT_HIT,
		EMIT_FINAL
	} emit_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_req;
		logic reg_write;
		logic srch_init;
		logic srch_rd;
		logic srch_step;
		logic set_write;
		logic shift_init;
		logic shift_step;
		logic shift_end;
		logic scan_init;
		logic scan_step;
		emit_t emit;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [2:0] cmd;
		logic full;
		logic srch_empty;
		logic srch_match;
		logic shift_done;
		logic scan_done;
		logic scan_emit_hit;
	} sts_t;

endpackage
`default_nettype wire

// File: rtl/core/sorted_box_table_with_overlap_query_unit.sv
// Top level of the sorted box table with overlap query.
//
// A request is taken at a rising edge where start is high and busy is low.
// Results appear on rsp for one cycle each, marked by rsp_valid; the
// receiver cannot stall them, and rsp.last flags the final result of a request.
// Register and unknown commands hold busy for one cycle and put their result
// out in the cycle after. Get, set and unregister run a binary search over the
// id-sorted table, each step a read then a compare on the single memory read port.
// Unregister then moves every later entry down by one, one entry per cycle.
// Overlap reads the stored entries in turn, one per cycle, until all are read or
// MAX_RESULTS hits are found; each hit goes out once the next is found, the last
// with the final result, and a query with no hits gives one empty result.
// One request is in work at a time. Reset empties the table and clears the
// id counter; no clearing pass is needed since only filled entries are read.
`default_nettype none
module sorted_box_table_with_overlap_query_unit #(
	parameter int TABLE_DEPTH = sbt_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire sbt_pkg::req_t req,
	output logic rsp_valid,
	output sbt_pkg::rsp_t rsp
);

	sbt_pkg::ctl_t ctl;
	sbt_pkg::sts_t sts;

	// Sequencing of each request.
	sbt_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.sts(sts),
		.ctl(ctl),
		.busy(busy)
	);

	// Table storage and arithmetic.
	sbt_dp #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.ctl(ctl),
		.sts(sts),
		.rsp(rsp),
		.rsp_valid(rsp_valid)
	);

endmodule
`default_nettype wire

// File: rtl/core/sbt_ctrl.sv
// Controller state machine of the sorted box table.
`default_nettype none
module sbt_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire sbt_pkg::sts_t sts,
	output sbt_pkg::ctl_t ctl,
	output logic busy
);

	sbt_pkg::state_t state_q;
	sbt_pkg::state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbt_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			sbt_pkg::S_IDLE: begin
				if (start) state_nxt = sbt_pkg::S_DISPATCH;
			end
			sbt_pkg::S_DISPATCH: begin
				unique case (sts.cmd)
					sbt_pkg::CMD_UNREGISTER, sbt_pkg::CMD_GET, sbt_pkg::CMD_SET:
						state_nxt = sbt_pkg::S_SRCH_RD;
					sbt_pkg::CMD_OVERLAP: state_nxt = sbt_pkg::S_SCAN;
					default: state_nxt = sbt_pkg::S_IDLE;
				endcase
			end
			sbt_pkg::S_SRCH_RD: begin
				state_nxt = sts.srch_empty ? sbt_pkg::S_IDLE : sbt_pkg::S_SRCH_CMP;
			end
			sbt_pkg::S_SRCH_CMP: begin
				if (!sts.srch_match) begin
					state_nxt = sbt_pkg::S_SRCH_RD;
				end else if (sts.cmd == sbt_pkg::CMD_UNREGISTER) begin
					state_nxt = sbt_pkg::S_SHIFT;
				end else begin
					state_nxt = sbt_pkg::S_IDLE;
				end
			end
			sbt_pkg::S_SHIFT: begin
				if (sts.shift_done) state_nxt = sbt_pkg::S_IDLE;
			end
			sbt_pkg::S_SCAN: begin
				if (sts.scan_done) state_nxt = sbt_pkg::S_SCAN_END;
			end
			sbt_pkg::S_SCAN_END: state_nxt = sbt_pkg::S_IDLE;
			default: state_nxt = sbt_pkg::S_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		ctl = '0;
		ctl.emit = sbt_pkg::EMIT_NONE;
		busy = (state_q != sbt_pkg::S_IDLE);
		unique case (state_q)
			sbt_pkg::S_IDLE: begin
				ctl.load_req = start;
			end
			sbt_pkg::S_DISPATCH: begin
				unique case (sts.cmd)
					sbt_pkg::CMD_REGISTER: begin
						ctl.reg_write = !sts.full;
						ctl.emit = sts.full ? sbt_pkg::EMIT_FULL : sbt_pkg::EMIT_REG;
					end
					sbt_pkg::CMD_UNREGISTER, sbt_pkg::CMD_GET, sbt_pkg::CMD_SET:
						ctl.srch_init = 1'b1;
					sbt_pkg::CMD_OVERLAP: ctl.scan_init = 1'b1;
					default: ctl.emit = sbt_pkg::EMIT_OK;
				endcase
			end
			sbt_pkg::S_SRCH_RD: begin
				if (sts.srch_empty) begin
					ctl.emit = sbt_pkg::EMIT_NOT_FOUND;
				end else begin
					ctl.srch_rd = 1'b1;
				end
			end
			sbt_pkg::S_SRCH_CMP: begin
				if (!sts.srch_match) begin
					ctl.srch_step = 1'b1;
				end else if (sts.cmd == sbt_pkg::CMD_UNREGISTER) begin
					ctl.shift_init = 1'b1;
				end else if (sts.cmd == sbt_pkg::CMD_GET) begin
					ctl.emit = sbt_pkg::EMIT_GET;
				end else begin
					ctl.set_write = 1'b1;
					ctl.emit = sbt_pkg::EMIT_OK;
				end
			end
			sbt_pkg::S_SHIFT: begin
				ctl.shift_step = 1'b1;
				if (sts.shift_done) begin
					ctl.shift_end = 1'b1;
					ctl.emit = sbt_pkg::EMIT_OK;
				end
			end
			sbt_pkg::S_SCAN: begin
				ctl.scan_step = 1'b1;
				if (sts.scan_emit_hit) ctl.emit = sbt_pkg::EMIT_HIT;
			end
			sbt_pkg::S_SCAN_END: ctl.emit = sbt_pkg::EMIT_FINAL;
			default: ctl.emit = sbt_pkg::EMIT_NONE;
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/core/sbt_dp.sv
// Datapath of the sorted box table: entry memory, search, shift and scan logic.
`default_nettype none
module sbt_dp #(
	parameter int TABLE_DEPTH = sbt_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire sbt_pkg::req_t req,
	input  wire sbt_pkg::ctl_t ctl,
	output sbt_pkg::sts_t sts,
	output sbt_pkg::rsp_t rsp,
	output logic rsp_valid
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [sbt_pkg::HIT_W-1:0] HIT_CAP = sbt_pkg::HIT_W'(sbt_pkg::MAX_RESULTS);

	sbt_pkg::entry_t mem [TABLE_DEPTH];

	sbt_pkg::req_t req_q;
	logic [CW-1:0] count_q;
	logic [sbt_pkg::NEXT_ID_W-1:0] next_id_q;
	logic [CW-1:0] lo_q;
	logic [CW-1:0] hi_q;
	logic [AW-1:0] mid_q;
	logic [CW-1:0] ptr_q;
	logic [AW-1:0] wr_ptr_q;
	logic rd_valid_s1;
	sbt_pkg::entry_t rd_data_s1;
	logic [sbt_pkg::HIT_W-1:0] hits_q;
	logic pend_valid_q;
	logic [sbt_pkg::ID_W-1:0] pend_id_q;
	sbt_pkg::rsp_t rsp_q;
	logic rsp_valid_q;

	logic [CW:0] mid_sum;
	logic [AW-1:0] mid_c;
	logic ptr_in_range;
	logic hits_open;
	logic scan_issue;
	logic shift_issue;
	logic rd_en;
	logic [AW-1:0] rd_addr;
	logic overlap;
	logic scan_hit;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	sbt_pkg::entry_t wr_data;
	sbt_pkg::entry_t req_box;
	sbt_pkg::rsp_t rsp_c;

	// Midpoint of the half-open search window.
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_c = mid_sum[AW:1];

	// Read port selection.
	assign ptr_in_range = (ptr_q < count_q);
	assign hits_open = (hits_q != HIT_CAP);
	assign scan_issue = ctl.scan_step && ptr_in_range && hits_open;
	assign shift_issue = ctl.shift_step && ptr_in_range;
	assign rd_en = ctl.srch_rd || scan_issue || shift_issue;
	assign rd_addr = ctl.srch_rd ? mid_c : ptr_q[AW-1:0];

	// Inclusive overlap test of the entry just read against the query box.
	assign overlap = (rd_data_s1.min_x <= req_q.max_x) && (req_q.min_x <= rd_data_s1.max_x) &&
		(rd_data_s1.min_y <= req_q.max_y) && (req_q.min_y <= rd_data_s1.max_y);
	assign scan_hit = rd_valid_s1 && overlap && hits_open;

	// Status toward the controller.
	always_comb begin
		sts.cmd = req_q.cmd;
		sts.full = (count_q == CW'(TABLE_DEPTH)) || next_id_q[sbt_pkg::NEXT_ID_W-1];
		sts.srch_empty = (lo_q >= hi_q);
		sts.srch_match = (rd_data_s1.id == req_q.box_id);
		sts.shift_done = !ptr_in_range && !rd_valid_s1;
		sts.scan_done = (!ptr_in_range || !hits_open) && !rd_valid_s1;
		sts.scan_emit_hit = scan_hit && pend_valid_q;
	end

	// Write port selection.
	always_comb begin
		req_box.id = rd_data_s1.id;
		req_box.min_x = req_q.min_x;
		req_box.min_y = req_q.min_y;
		req_box.max_x = req_q.max_x;
		req_box.max_y = req_q.max_y;
		wr_en = 1'b0;
		wr_addr = wr_ptr_q;
		wr_data = rd_data_s1;
		if (ctl.reg_write) begin
			wr_en = 1'b1;
			wr_addr = count_q[AW-1:0];
			wr_data = req_box;
			wr_data.id = next_id_q[sbt_pkg::ID_W-1:0];
		end else if (ctl.set_write) begin
			wr_en = 1'b1;
			wr_addr = mid_q;
			wr_data = req_box;
		end else if (ctl.shift_step && rd_valid_s1) begin
			wr_en = 1'b1;
		end
	end

	// Entry memory with a registered read.
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data_s1 <= mem[rd_addr];
	end

	// Request latch, id of the pending hit, search midpoint and result register.
	always_ff @(posedge clk) begin
		if (ctl.load_req) req_q <= req;
		if (ctl.scan_step && scan_hit) pend_id_q <= rd_data_s1.id;
		if (ctl.srch_rd) mid_q <= mid_c;
		rsp_q <= rsp_c;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			next_id_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			ptr_q <= '0;
			wr_ptr_q <= '0;
			rd_valid_s1 <= 1'b0;
			hits_q <= '0;
			pend_valid_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= scan_issue || shift_issue;
			rsp_valid_q <= (ctl.emit != sbt_pkg::EMIT_NONE);
			if (ctl.reg_write) begin
				count_q <= count_q + CW'(1);
				next_id_q <= next_id_q + sbt_pkg::NEXT_ID_W'(1);
			end
			if (ctl.srch_init) begin
				lo_q <= '0;
				hi_q <= count_q;
			end
			if (ctl.srch_step) begin
				if (rd_data_s1.id < req_q.box_id) begin
					lo_q <= CW'(mid_q) + CW'(1);
				end else begin
					hi_q <= CW'(mid_q);
				end
			end
			if (ctl.shift_init) begin
				ptr_q <= CW'(mid_q) + CW'(1);
				wr_ptr_q <= mid_q;
			end
			if (shift_issue || scan_issue) ptr_q <= ptr_q + CW'(1);
			if (ctl.shift_step && rd_valid_s1) wr_ptr_q <= wr_ptr_q + AW'(1);
			if (ctl.shift_end) count_q <= count_q - CW'(1);
			if (ctl.scan_init) begin
				ptr_q <= '0;
				hits_q <= '0;
				pend_valid_q <= 1'b0;
			end
			if (ctl.scan_step && scan_hit) begin
				pend_valid_q <= 1'b1;
				hits_q <= hits_q + sbt_pkg::HIT_W'(1);
			end
		end
	end

	// Result formatting.
	always_comb begin
		rsp_c = '0;
		rsp_c.last = 1'b1;
		case (ctl.emit)
			sbt_pkg::EMIT_REG: rsp_c.result_id = next_id_q[sbt_pkg::ID_W-1:0];
			sbt_pkg::EMIT_FULL: rsp_c.status = sbt_pkg::ST_FULL;
			sbt_pkg::EMIT_NOT_FOUND: rsp_c.status = sbt_pkg::ST_NOT_FOUND;
			sbt_pkg::EMIT_GET: begin
				rsp_c.out_min_x = rd_data_s1.min_x;
				rsp_c.out_min_y = rd_data_s1.min_y;
				rsp_c.out_max_x = rd_data_s1.max_x;
				rsp_c.out_max_y = rd_data_s1.max_y;
			end
			sbt_pkg::EMIT_HIT: begin
				rsp_c.result_id = pend_id_q;
				rsp_c.hit = 1'b1;
				rsp_c.last = 1'b0;
			end
			sbt_pkg::EMIT_FINAL: begin
				if (pend_valid_q) begin
					rsp_c.result_id = pend_id_q;
					rsp_c.hit = 1'b1;
				end
			end
			default: rsp_c.last = 1'b1;
		endcase
	end

	assign rsp = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule
`default_nettype wire
